// File: hw/rtl/tws_pkg.sv
// shared codes, state encoding and controller/datapath interface structs
`timescale 1ns / 1ps

package tws_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_LAUNCH_H = 6'b000010,
        S_WAIT_H   = 6'b000100,
        S_GEOM     = 6'b001000,
        S_WAIT_I   = 6'b010000,
        S_MUL      = 6'b100000
    } t_state;

    typedef struct packed {
        logic load_start;
        logic tick;
        logic div_go;
        logic div_sel_inc;
        logic latch_height;
        logic geom;
        logic latch_inc;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic height_zero;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/tws_in_if.sv
// input channel: column start and row tick transactions
`timescale 1ns / 1ps

interface tws_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [9:0]         column_index;
    logic [23:0]        wall_distance;
    logic               hit_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        viewer_x;
    logic [23:0]        viewer_y;

    modport source (
        output valid, operation, column_index, wall_distance, hit_side,
               dir_x, dir_y, viewer_x, viewer_y,
        input  ready
    );
    modport sink (
        input  valid, operation, column_index, wall_distance, hit_side,
               dir_x, dir_y, viewer_x, viewer_y,
        output ready
    );
endinterface

// File: hw/rtl/tws_out_if.sv
// output channel: one pixel coordinate transaction per drawn row
`timescale 1ns / 1ps

interface tws_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] screen_col;
    logic [8:0] screen_row;
    logic [5:0] texel_col;
    logic [5:0] texel_row;
    logic       last_row;

    modport source (
        output valid, screen_col, screen_row, texel_col, texel_row, last_row,
        input  ready
    );
    modport sink (
        input  valid, screen_col, screen_row, texel_col, texel_row, last_row,
        output ready
    );
endinterface

// File: hw/rtl/tws_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tws_div #(
    parameter int NUMW = 26,
    parameter int DENW = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo
);

    localparam int CW = $clog2(NUMW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DENW:0]   r_rem;
    logic [NUMW-1:0] r_q;
    logic [DENW-1:0] r_den;

    logic [DENW:0]   n_rem_sh;
    logic            n_fits;

    always_comb begin
        n_rem_sh = {r_rem[DENW-1:0], r_q[NUMW-1]};
        n_fits   = (n_rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(NUMW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= n_fits ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            r_q   <= {r_q[NUMW-2:0], n_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: hw/rtl/tws_ctrl.sv
// column setup sequencer and input handshake control
`timescale 1ns / 1ps

module tws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    input  tws_pkg::t_status i_status,
    output logic             o_in_ready,
    output tws_pkg::t_cmd    o_cmd
);

    tws_pkg::t_state r_state;
    tws_pkg::t_state n_state;
    logic            n_accept;

    always_comb begin
        o_in_ready = (r_state == tws_pkg::S_IDLE) && i_status.out_free;
        n_accept   = o_in_ready && i_in_valid;

        o_cmd              = '0;
        o_cmd.load_start   = n_accept && (i_in_op == tws_pkg::OP_START);
        o_cmd.tick         = n_accept && (i_in_op == tws_pkg::OP_TICK);
        o_cmd.div_go       = (r_state == tws_pkg::S_LAUNCH_H) ||
                             ((r_state == tws_pkg::S_GEOM) && !i_status.height_zero);
        o_cmd.div_sel_inc  = (r_state == tws_pkg::S_GEOM);
        o_cmd.latch_height = (r_state == tws_pkg::S_WAIT_H) && i_status.div_done;
        o_cmd.geom         = (r_state == tws_pkg::S_GEOM);
        o_cmd.latch_inc    = (r_state == tws_pkg::S_WAIT_I) && i_status.div_done;
        o_cmd.commit       = (r_state == tws_pkg::S_MUL);

        n_state = r_state;
        case (r_state)
            tws_pkg::S_IDLE: begin
                if (o_cmd.load_start) n_state = tws_pkg::S_LAUNCH_H;
            end
            tws_pkg::S_LAUNCH_H: begin
                n_state = tws_pkg::S_WAIT_H;
            end
            tws_pkg::S_WAIT_H: begin
                if (i_status.div_done) n_state = tws_pkg::S_GEOM;
            end
            tws_pkg::S_GEOM: begin
                // zero height skips the step division, it saturates instead
                n_state = i_status.height_zero ? tws_pkg::S_MUL : tws_pkg::S_WAIT_I;
            end
            tws_pkg::S_WAIT_I: begin
                if (i_status.div_done) n_state = tws_pkg::S_MUL;
            end
            tws_pkg::S_MUL: begin
                n_state = tws_pkg::S_IDLE;
            end
            default: begin
                n_state = tws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/tws_datapath.sv
// column geometry, texture mapping, row stepping and output register
`timescale 1ns / 1ps

module tws_datapath #(
    parameter int SCREEN_ROWS    = 512,
    parameter int TEXTURE_WIDTH  = 64,
    parameter int TEXTURE_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tws_pkg::t_cmd      i_cmd,
    output tws_pkg::t_status   o_status,
    input  logic [9:0]         i_column_index,
    input  logic [23:0]        i_wall_distance,
    input  logic               i_hit_side,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic [23:0]        i_viewer_x,
    input  logic [23:0]        i_viewer_y,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [9:0]         o_screen_col,
    output logic [8:0]         o_screen_row,
    output logic [5:0]         o_texel_col,
    output logic [5:0]         o_texel_row,
    output logic               o_last_row
);

    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int HW    = $clog2(SCREEN_ROWS + 1) + 16;
    localparam int THNW  = $clog2(TEXTURE_HEIGHT + 1) + 16;
    localparam int NUMW  = (HW > THNW) ? HW : THNW;
    localparam int DENW  = (HW > 24) ? HW : 24;
    localparam int TCW   = $clog2(TEXTURE_WIDTH);
    localparam int TWW   = $clog2(TEXTURE_WIDTH + 1);
    localparam int THW   = $clog2(TEXTURE_HEIGHT);
    localparam int HALF_ROWS = SCREEN_ROWS / 2;

    localparam logic [NUMW-1:0] NUM_HEIGHT = NUMW'(SCREEN_ROWS * 65536);
    localparam logic [NUMW-1:0] NUM_STEP   = NUMW'(TEXTURE_HEIGHT * 65536);

    // start item operands
    logic [23:0]     r_dist;
    logic [29:0]     r_prod;
    logic [15:0]     r_pos_lo;
    logic            r_mirror;

    // setup results
    logic [HW-1:0]   r_height;
    logic [HW-1:0]   r_offs;

    // column stepping state
    logic [9:0]      r_cur_col;
    logic [RW-1:0]   r_cur_row;
    logic [RW-1:0]   r_end_row;
    logic [TCW-1:0]  r_tex_col;
    logic [31:0]     r_tex_pos;
    logic [31:0]     r_tex_inc;
    logic            r_active;

    // output register
    logic            r_out_valid;
    logic [9:0]      r_o_col;
    logic [8:0]      r_o_row;
    logic [5:0]      r_o_tcol;
    logic [5:0]      r_o_trow;
    logic            r_o_last;

    logic [NUMW-1:0] n_div_num;
    logic [DENW-1:0] n_div_den;
    logic            n_div_done;
    logic [NUMW-1:0] n_div_quo;

    logic signed [40:0] n_prod_full;
    logic [29:0]        n_frac;
    logic [30+TWW-1:0]  n_scaled;
    logic [TCW-1:0]     n_col;
    logic [HW:0]        n_half;
    logic [HW:0]        n_start;
    logic [HW:0]        n_end;
    logic [HW:0]        n_offs;
    logic               n_last;
    logic               n_out_free;

    always_comb begin
        n_div_num = i_cmd.div_sel_inc ? NUM_STEP : NUM_HEIGHT;
        if (i_cmd.div_sel_inc) begin
            n_div_den = DENW'(r_height);
        end else begin
            // zero distance counts as one lsb
            n_div_den = (r_dist == 24'd0) ? DENW'(1) : DENW'(r_dist);
        end
    end

    tws_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (n_div_done),
        .o_quo   (n_div_quo)
    );

    always_comb begin
        n_prod_full = $signed({1'b0, i_wall_distance}) *
                      (i_hit_side ? i_dir_x : i_dir_y);

        // fractional wall hit, q.30 modulo one map unit
        n_frac   = {r_pos_lo, 14'd0} + r_prod;
        n_scaled = {{TWW{1'b0}}, n_frac} * (30 + TWW)'(TEXTURE_WIDTH);
        n_col    = n_scaled[30 +: TCW];
        if (r_mirror) begin
            n_col = TCW'(TEXTURE_WIDTH - 1) - n_col;
        end

        n_half  = (HW + 1)'(r_height >> 1);
        n_start = (n_half >= (HW + 1)'(HALF_ROWS)) ? '0 : (HW + 1)'(HALF_ROWS) - n_half;
        n_end   = n_half + (HW + 1)'(HALF_ROWS);
        if (n_end >= (HW + 1)'(SCREEN_ROWS)) begin
            n_end = (HW + 1)'(SCREEN_ROWS - 1);
        end
        // rows clipped off the top still advance the texture
        n_offs  = (n_half > (HW + 1)'(HALF_ROWS)) ? n_half - (HW + 1)'(HALF_ROWS) : '0;

        n_last     = (r_cur_row >= r_end_row);
        n_out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_dist    <= i_wall_distance;
            r_prod    <= n_prod_full[29:0];
            r_pos_lo  <= i_hit_side ? i_viewer_x[15:0] : i_viewer_y[15:0];
            r_mirror  <= (!i_hit_side && (i_dir_x > 16'sd0)) ||
                         (i_hit_side && (i_dir_y < 16'sd0));
            r_cur_col <= i_column_index;
        end
        if (i_cmd.latch_height) begin
            r_height <= HW'(n_div_quo);
        end
        if (i_cmd.geom) begin
            r_cur_row <= RW'(n_start);
            r_end_row <= RW'(n_end);
            r_tex_col <= n_col;
            if (r_height == '0) begin
                r_tex_inc <= '1;
                r_offs    <= '0;
            end else begin
                r_offs    <= HW'(n_offs);
            end
        end
        if (i_cmd.latch_inc) begin
            r_tex_inc <= 32'(n_div_quo);
        end
        if (i_cmd.commit) begin
            r_tex_pos <= 32'(r_offs * r_tex_inc);
        end else if (i_cmd.tick && r_active) begin
            r_tex_pos <= r_tex_pos + r_tex_inc;
            r_cur_row <= r_cur_row + RW'(1);
        end
        if (i_cmd.tick && r_active) begin
            r_o_col  <= r_cur_col;
            r_o_row  <= 9'(r_cur_row);
            r_o_tcol <= 6'(r_tex_col);
            r_o_trow <= 6'(r_tex_pos[16 +: THW]);
            r_o_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_active <= 1'b1;
            end else if (i_cmd.tick && r_active && n_last) begin
                r_active <= 1'b0;
            end
            if (i_cmd.tick && r_active) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.div_done    = n_div_done;
        o_status.height_zero = (r_height == '0);
        o_status.out_free    = n_out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_screen_col = r_o_col;
    assign o_screen_row = r_o_row;
    assign o_texel_col  = r_o_tcol;
    assign o_texel_row  = r_o_trow;
    assign o_last_row   = r_o_last;

endmodule

// File: hw/rtl/textured_wall_column_stepper.sv
// Textured wall column stepper: a start transaction sets up one wall column (line height,
// clipped row span, texture column, texture step and start) and produces no output; each
// tick transaction then emits one screen row with its texel coordinates, flagging the last
// row. Ticks run at one per cycle while the output keeps up. A start occupies the block until
// its setup is done: the height and the texture step come from one shared restoring divider
// that yields one quotient bit per cycle, followed by one multiply for the texture start. A
// tick with no column in progress is consumed without a result. TEXTURE_WIDTH and
// TEXTURE_HEIGHT are powers of two.
`timescale 1ns / 1ps

module textured_wall_column_stepper #(
    parameter int SCREEN_ROWS    = 512,
    parameter int TEXTURE_WIDTH  = 64,
    parameter int TEXTURE_HEIGHT = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tws_in_if.sink    i_in_chan,
    tws_out_if.source o_out_chan
);

    tws_pkg::t_cmd    n_cmd;
    tws_pkg::t_status n_status;

    tws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_chan.valid),
        .i_in_op    (i_in_chan.operation),
        .i_status   (n_status),
        .o_in_ready (i_in_chan.ready),
        .o_cmd      (n_cmd)
    );

    tws_datapath #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TEXTURE_WIDTH  (TEXTURE_WIDTH),
        .TEXTURE_HEIGHT (TEXTURE_HEIGHT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (n_cmd),
        .o_status        (n_status),
        .i_column_index  (i_in_chan.column_index),
        .i_wall_distance (i_in_chan.wall_distance),
        .i_hit_side      (i_in_chan.hit_side),
        .i_dir_x         (i_in_chan.dir_x),
        .i_dir_y         (i_in_chan.dir_y),
        .i_viewer_x      (i_in_chan.viewer_x),
        .i_viewer_y      (i_in_chan.viewer_y),
        .i_out_ready     (o_out_chan.ready),
        .o_out_valid     (o_out_chan.valid),
        .o_screen_col    (o_out_chan.screen_col),
        .o_screen_row    (o_out_chan.screen_row),
        .o_texel_col     (o_out_chan.texel_col),
        .o_texel_row     (o_out_chan.texel_row),
        .o_last_row      (o_out_chan.last_row)
    );

endmodule

// File: hw/rtl/tws_checker.sv
// port level checks for the column stepper, bound to the top level
`timescale 1ns / 1ps

module tws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_screen_col,
    input logic [8:0] i_screen_row,
    input logic [5:0] i_texel_col,
    input logic       i_last_row
);

    logic n_out_acc;
    assign n_out_acc = i_out_valid && i_out_ready;

    // no pending transaction right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    // a stalled output blocks new input transactions
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    // back to back rows of one column step by one row
    a_row_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_acc && !i_last_row ##1 n_out_acc) |->
            (i_screen_row == 9'($past(i_screen_row) + 9'd1)) &&
            (i_screen_col == $past(i_screen_col)) &&
            (i_texel_col == $past(i_texel_col)))
        else $error("row sequence broken within a column");

endmodule

bind textured_wall_column_stepper tws_checker u_tws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in_chan.ready),
    .i_out_valid  (o_out_chan.valid),
    .i_out_ready  (o_out_chan.ready),
    .i_screen_col (o_out_chan.screen_col),
    .i_screen_row (o_out_chan.screen_row),
    .i_texel_col  (o_out_chan.texel_col),
    .i_last_row   (o_out_chan.last_row)
);

// File: sim/textured_wall_column_stepper_tb.sv
// self-checking testbench for the textured wall column stepper
`timescale 1ns / 1ps

module textured_wall_column_stepper_tb;

    localparam int SCREEN_ROWS    = 512;
    localparam int TEXTURE_WIDTH  = 64;
    localparam int TEXTURE_HEIGHT = 64;
    localparam int ITEM_TARGET    = 1850;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} t_chk_kind;

    typedef struct {
        logic               op;
        bit [9:0]           col;
        bit [23:0]          wall_dist;
        bit                 side;
        bit signed [15:0]   dx;
        bit signed [15:0]   dy;
        bit [23:0]          vx;
        bit [23:0]          vy;
    } t_column_cmd;

    typedef struct packed {
        bit [9:0] scol;
        bit [8:0] srow;
        bit [5:0] tcol;
        bit [5:0] trow;
        bit       last;
    } t_pixel;

    typedef struct {
        t_column_cmd cmd;
        t_chk_kind   kind;
        t_pixel      px;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    tws_in_if  in_ch ();
    tws_out_if out_ch ();

    textured_wall_column_stepper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_ch),
        .o_out_chan (out_ch)
    );

    // column state mirrored from the block
    bit [9:0]    col_now;
    int unsigned row_now;
    int unsigned row_end;
    bit [5:0]    tex_col;
    bit [31:0]   tex_pos;
    bit [31:0]   tex_inc;
    bit          col_open;

    t_pixel      pending_pixels[$];
    t_script_row script[$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int cycles;
    int n_errors;
    int n_sent;
    int n_starts;
    int n_stray;
    int n_checked;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycles, pending_pixels.size());
            $display("textured_wall_column_stepper_tb: errors");
            $finish;
        end
    end

    // long output hold, counted down here
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left--;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic note_error(input string what, input t_pixel want, input t_pixel got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%s: want %0d/%0d tex %0d,%0d last %0b | got %0d/%0d tex %0d,%0d last %0b",
                     what, want.scol, want.srow, want.tcol, want.trow, want.last,
                     got.scol, got.srow, got.tcol, got.trow, got.last);
    endtask

    always @(posedge i_clk) begin : check_pixel
        t_pixel got;
        t_pixel want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.screen_col, out_ch.screen_row, out_ch.texel_col,
                    out_ch.texel_row, out_ch.last_row};
            if (pending_pixels.size() == 0) begin
                note_error("pixel with none pending", '0, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.scol != want.scol || got.srow != want.srow ||
                    got.tcol != want.tcol || got.trow != want.trow ||
                    got.last != want.last)
                    note_error("pixel mismatch", want, got);
            end
            n_checked++;
        end
    end

    // setup on a start, one pixel per tick while a column is open
    task automatic advance_column(input t_column_cmd c, output bit made, output t_pixel px);
        longint divisor;
        longint height;
        longint half;
        longint top;
        longint bottom;
        longint posv;
        longint dirv;
        longint hit;
        longint frac;
        bit     last;
        made = 1'b0;
        px = '0;
        if (c.op == tws_pkg::OP_START) begin
            divisor = (c.wall_dist == 0) ? 64'sd1 : longint'(c.wall_dist);
            height  = (longint'(SCREEN_ROWS) <<< 16) / divisor;
            half    = height / 2;
            top     = SCREEN_ROWS / 2 - half;
            bottom  = half + SCREEN_ROWS / 2;
            if (top < 0)
                top = 0;
            if (bottom >= SCREEN_ROWS)
                bottom = SCREEN_ROWS - 1;
            posv = c.side ? longint'(c.vx) : longint'(c.vy);
            dirv = c.side ? c.dx : c.dy;
            // exact hit in q.30, only the fraction matters
            hit  = (posv <<< 14) + longint'(c.wall_dist) * dirv;
            frac = hit & ((64'sd1 <<< 30) - 1);
            tex_col = 6'((frac * TEXTURE_WIDTH) >>> 30);
            if ((c.side == 1'b0 && c.dx > 0) || (c.side == 1'b1 && c.dy < 0))
                tex_col = 6'(TEXTURE_WIDTH - 1 - tex_col);
            if (height == 0) begin
                tex_inc = '1;
                tex_pos = '0;
            end else begin
                tex_inc = 32'((longint'(TEXTURE_HEIGHT) <<< 16) / height);
                tex_pos = 32'((top - SCREEN_ROWS / 2 + half) * longint'(tex_inc));
            end
            col_now  = c.col;
            row_now  = int'(top);
            row_end  = int'(bottom);
            col_open = 1'b1;
        end else if (col_open) begin
            last    = row_now >= row_end;
            made    = 1'b1;
            px.scol = col_now;
            px.srow = row_now[8:0];
            px.tcol = tex_col;
            px.trow = 6'((tex_pos >> 16) & (TEXTURE_HEIGHT - 1));
            px.last = last;
            tex_pos += tex_inc;
            row_now += 1;
            if (last)
                col_open = 1'b0;
        end
    endtask

    task automatic send_item(input t_column_cmd c, input t_chk_kind kind, input t_pixel given);
        bit     made;
        t_pixel px;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.operation     <= c.op;
        in_ch.column_index  <= c.col;
        in_ch.wall_distance <= c.wall_dist;
        in_ch.hit_side      <= c.side;
        in_ch.dir_x         <= c.dx;
        in_ch.dir_y         <= c.dy;
        in_ch.viewer_x      <= c.vx;
        in_ch.viewer_y      <= c.vy;
        in_ch.valid         <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (c.op == tws_pkg::OP_TICK && !col_open)
            n_stray++;
        if (c.op == tws_pkg::OP_START)
            n_starts++;
        n_sent++;
        advance_column(c, made, px);
        if (kind == CHK_GIVEN)
            pending_pixels.push_back(given);
        else if (kind == CHK_MODEL && made)
            pending_pixels.push_back(px);
        @(negedge i_clk);
    endtask

    task automatic plan(input logic op, input bit [9:0] col, input bit [23:0] wall_dist,
                        input bit side, input bit signed [15:0] dx, input bit signed [15:0] dy,
                        input bit [23:0] vx, input bit [23:0] vy, input t_chk_kind kind,
                        input bit [9:0] scol, input bit [8:0] srow, input bit [5:0] tcol,
                        input bit [5:0] trow, input bit last);
        t_script_row r;
        r.cmd  = '{op, col, wall_dist, side, dx, dy, vx, vy};
        r.kind = kind;
        r.px   = '{scol, srow, tcol, trow, last};
        script.push_back(r);
    endtask

    function automatic t_column_cmd random_cmd(input logic op);
        t_column_cmd c;
        c.op   = op;
        c.col  = 10'($urandom);
        c.side = 1'($urandom);
        c.dx   = 16'($urandom);
        c.dy   = 16'($urandom);
        c.vx   = 24'($urandom);
        c.vy   = 24'($urandom);
        case ($urandom_range(0, 9))
            0:       c.wall_dist = 24'($urandom_range(24'h008000, 24'h03FFFF));
            1, 2, 3,
            4, 5:    c.wall_dist = 24'($urandom_range(24'h040000, 24'h1FFFFF));
            6, 7, 8: c.wall_dist = 24'($urandom_range(24'h200000, 24'hFFFFFF));
            default: c.wall_dist = 24'($urandom);
        endcase
        return c;
    endfunction

    initial begin : stimulus
        t_column_cmd c;
        int          rows;
        int          nticks;
        int          phase;
        int          base;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = tws_pkg::OP_TICK;
        in_ch.column_index = '0;
        in_ch.wall_distance = '0;
        in_ch.hit_side = 1'b0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.viewer_x = '0;
        in_ch.viewer_y = '0;
        out_ch.ready = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;

        // tick before any column, zero distance, farthest wall, mirrored sides,
        // column abandoned by a new start, tick column index ignored
        plan(tws_pkg::OP_TICK,  10'd9,   24'h000000, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd1023, 24'h000000, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK,  10'd5,   24'h000000, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_GIVEN, 1023, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK,  10'd0,   24'hFFFFFF, 1'b1, -1, -1, 24'hFFFFFF, 24'hFFFFFF,
             CHK_GIVEN, 1023, 1, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd0,   24'hFFFFFF, 1'b1, 0, -32768, 24'h0, 24'hFFFFFF,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK,  10'd0,   24'h0, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_GIVEN, 0, 255, 63, 0, 0);
        plan(tws_pkg::OP_TICK,  10'd0,   24'h0, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_GIVEN, 0, 256, 63, 32, 0);
        plan(tws_pkg::OP_TICK,  10'd0,   24'h0, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_GIVEN, 0, 257, 63, 0, 1);
        plan(tws_pkg::OP_TICK,  10'd0,   24'h0, 1'b0, 0, 0, 24'h0, 24'h0,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd300, 24'h010000, 1'b0, 16384, 8192, 24'h028000, 24'h034000,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd77,  24'h028000, 1'b1, -12000, -20000, 24'hFFFFFF, 24'h123456,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd512, 24'h00C000, 1'b0, 32767, -32768, 24'h7FFFFF, 24'h800001,
             CHK_NONE, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0, CHK_MODEL, 0, 0, 0, 0, 0);
        plan(tws_pkg::OP_START, 10'd640, 24'h400000, 1'b1, -32768, 32767, 24'h000001, 24'hABCDEF,
             CHK_NONE, 0, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            plan(tws_pkg::OP_TICK, 10'd0, 24'h0, 1'b0, 0, 0, 24'h0, 24'h0,
                 CHK_MODEL, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i])
            send_item(script[i].cmd, script[i].kind, script[i].px);

        // full-screen column with the output held off, so the block backs up
        base = n_sent - n_stray;
        c = random_cmd(tws_pkg::OP_START);
        c.wall_dist = 24'h010000;
        send_item(c, CHK_MODEL, '0);
        hold_left = HOLD_CYCLES;
        repeat (40)
            send_item(random_cmd(tws_pkg::OP_TICK), CHK_MODEL, '0);

        while (n_sent - n_stray - base < ITEM_TARGET) begin
            phase = (n_sent - n_stray - base) * 4 / ITEM_TARGET;
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            if ($urandom_range(0, 7) == 0)
                send_item(random_cmd(tws_pkg::OP_TICK), CHK_MODEL, '0);
            send_item(random_cmd(tws_pkg::OP_START), CHK_MODEL, '0);
            rows = int'(row_end) - int'(row_now) + 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: nticks = rows;
                6, 7, 8:          nticks = $urandom_range(0, rows < 12 ? rows : 12);
                default:          nticks = rows + $urandom_range(1, 3);
            endcase
            // keep the total close to the target
            if (nticks > ITEM_TARGET - (n_sent - n_stray - base))
                nticks = ITEM_TARGET - (n_sent - n_stray - base);
            repeat (nticks)
                send_item(random_cmd(tws_pkg::OP_TICK), CHK_MODEL, '0);
        end
        in_ch.valid <= 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d transactions in (%0d column starts, %0d ticks with no column open)",
                 n_sent, n_starts, n_stray);
        $display("%0d pixels checked; idle mixes none, 64/0, 0/64, 15/15; one %0d-cycle hold",
                 n_checked, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("textured_wall_column_stepper_tb: clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("textured_wall_column_stepper_tb: errors");
        end
        $finish;
    end

endmodule
